// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: rtl/core/ean8r_pkg.sv
package ean8r_pkg;

   // Modules in one row: guard, four digits, center, four digits, guard.
   localparam logic [6:0] MODULES = 7'd67;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODULE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_MARGIN_WIDTH = 2'd1;
   localparam logic [1:0] CSR_BAR_HEIGHT   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [4:0] MODULE_WIDTH_RST = 5'd3;
   localparam logic [6:0] MARGIN_WIDTH_RST = 7'd4;
   localparam logic [9:0] BAR_HEIGHT_RST   = 10'd50;

   typedef enum logic [1:0] {
      PH_LEFT  = 2'd0,
      PH_BARS  = 2'd1,
      PH_RIGHT = 2'd2
   } phase_type;

   typedef struct packed {
      logic check_ok;
      logic digit_error;
   } code_status_type;

   typedef struct packed {
      logic pixel;
      logic row_end;
      logic image_end;
   } pix_info_type;

   // L-code pattern of a decimal digit, first module in bit 6.
   function automatic logic [6:0] lcode(input logic [3:0] d);
      logic [6:0] pat;
      case (d)
         4'd0:    pat = 7'h0D;
         4'd1:    pat = 7'h19;
         4'd2:    pat = 7'h13;
         4'd3:    pat = 7'h3D;
         4'd4:    pat = 7'h23;
         4'd5:    pat = 7'h31;
         4'd6:    pat = 7'h2F;
         4'd7:    pat = 7'h3B;
         4'd8:    pat = 7'h37;
         4'd9:    pat = 7'h0B;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

   // Color of one module of the row for the given code (1 is black).
   function automatic logic module_bit(input logic [31:0] code, input logic [6:0] idx);
      logic        res;
      logic        right;
      logic [6:0]  tmp;
      logic [6:0]  rel;
      logic [1:0]  dn;
      logic [6:0]  bsel_w;
      logic [2:0]  bsel;
      logic [2:0]  pos;
      logic [31:0] shifted;
      logic [3:0]  d;
      logic [6:0]  pat;
      res     = 1'b0;
      right   = (idx >= 7'd36);
      tmp     = idx - 7'd31;
      rel     = right ? (idx - 7'd36) : (idx - 7'd3);
      if (rel >= 7'd21) begin
         dn = 2'd3;
      end else if (rel >= 7'd14) begin
         dn = 2'd2;
      end else if (rel >= 7'd7) begin
         dn = 2'd1;
      end else begin
         dn = 2'd0;
      end
      bsel_w  = rel - (7'(dn) * 7'd7);
      bsel    = bsel_w[2:0];
      pos     = {right, dn};
      shifted = code >> {~pos, 2'b00};
      d       = shifted[3:0];
      pat     = lcode(d);
      if (right) begin
         pat = ~pat;
      end
      if (idx < 7'd3) begin
         res = (idx != 7'd1);
      end else if (idx >= 7'd64) begin
         res = (idx != 7'd65);
      end else if (idx >= 7'd31 && idx < 7'd36) begin
         res = tmp[0];
      end else if (d > 4'd9) begin
         res = 1'b0;
      end else begin
         res = pat[3'd6 - bsel];
      end
      return res;
   endfunction

endpackage

// File: rtl/core/ean8r_check.sv
module ean8r_check
   import ean8r_pkg::*;
(
   input  logic [31:0]     code,
   output code_status_type status
);

   logic [3:0]  digit [8];
   logic [7:0]  sum;
   logic        bad;
   logic [14:0] quot_w;
   logic [3:0]  quot;
   logic [7:0]  rem_w;
   logic [3:0]  rem;
   logic [3:0]  expected;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digit[i] = code[4*(7-i) +: 4];
      end
   end

   always_comb begin
      bad = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (digit[i] > 4'd9) begin
            bad = 1'b1;
         end
      end
   end

   // Weights 3,1,3,... counted leftward from the seventh digit.
   always_comb begin
      sum = 8'd0;
      for (int i = 0; i < 7; i++) begin
         if ((i % 2) == 0) begin
            sum = sum + {3'b000, digit[i], 1'b0} + {4'b0000, digit[i]};
         end else begin
            sum = sum + {4'b0000, digit[i]};
         end
      end
   end

   // The sum stays below 136, so multiplying by 205 and dropping 11 bits
   // gives the exact quotient by ten.
   assign quot_w   = (15'(sum) * 15'd205) >> 11;
   assign quot     = quot_w[3:0];
   assign rem_w    = sum - (8'(quot) * 8'd10);
   assign rem      = rem_w[3:0];
   assign expected = (rem == 4'd0) ? 4'd0 : (4'd10 - rem);

   assign status.digit_error = bad;
   assign status.check_ok    = !bad && (expected == digit[7]);

endmodule

// File: rtl/core/ean8r_raster.sv
`include "assert_macros.svh"

module ean8r_raster
   import ean8r_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_wdata,
   input  logic         restart,
   input  logic         step,
   input  logic [31:0]  code,
   output pix_info_type pix
);

   logic [4:0]  module_width_ff, module_width_in;
   logic [6:0]  margin_width_ff, margin_width_in;
   logic [9:0]  bar_height_ff, bar_height_in;
   phase_type   phase_ff, phase_in;
   logic [6:0]  margin_count_ff, margin_count_in;
   logic [6:0]  module_index_ff, module_index_in;
   logic [3:0]  width_count_ff, width_count_in;
   logic [9:0]  row_count_ff, row_count_in;

   logic [4:0]  mw_eff;
   logic [6:0]  m_eff;
   logic [9:0]  h_eff;
   logic [6:0]  idx_cur;
   logic [4:0]  wc_sum;
   logic        wc_wrap;
   logic [6:0]  idx_sum;
   logic        last_module;
   logic [7:0]  mc_sum;
   logic        mc_wrap;
   logic [10:0] rc_sum;
   logic        last_row;
   logic        row_done;
   logic        img_done;
   logic        cfg_hit;
   logic [6:0]  margin_next;
   phase_type   start_phase;

   // Out-of-range register values are clamped into the usable range.
   assign mw_eff = (module_width_ff == 5'd0) ? 5'd1 :
                   (module_width_ff > 5'd16) ? 5'd16 : module_width_ff;
   assign m_eff  = (margin_width_ff > 7'd64) ? 7'd64 : margin_width_ff;
   assign h_eff  = (bar_height_ff == 10'd0) ? 10'd1 : bar_height_ff;

   assign idx_cur     = (module_index_ff >= MODULES) ? 7'd0 : module_index_ff;
   assign wc_sum      = {1'b0, width_count_ff} + 5'd1;
   assign wc_wrap     = (wc_sum >= mw_eff);
   assign idx_sum     = idx_cur + 7'd1;
   assign last_module = (idx_sum >= MODULES);
   assign mc_sum      = {1'b0, margin_count_ff} + 8'd1;
   assign mc_wrap     = (mc_sum >= {1'b0, m_eff});
   assign rc_sum      = {1'b0, row_count_ff} + 11'd1;
   assign last_row    = (rc_sum >= {1'b0, h_eff});

   // A register write restarts the raster with the margin that is in force after it.
   assign cfg_hit     = csr_we && (csr_index == CSR_MODULE_WIDTH ||
                                   csr_index == CSR_MARGIN_WIDTH ||
                                   csr_index == CSR_BAR_HEIGHT);
   assign margin_next = (csr_we && csr_index == CSR_MARGIN_WIDTH) ? csr_wdata[6:0]
                                                                 : margin_width_ff;
   assign start_phase = (margin_next == 7'd0) ? PH_BARS : PH_LEFT;

   // Outputs of the current position.
   always_comb begin
      pix.pixel = 1'b0;
      row_done  = 1'b0;
      case (phase_ff)
         PH_BARS: begin
            pix.pixel = module_bit(code, idx_cur);
            row_done  = wc_wrap && last_module && (m_eff == 7'd0);
         end
         PH_RIGHT: begin
            row_done = mc_wrap;
         end
         default: begin
            row_done = 1'b0;
         end
      endcase
      img_done      = row_done && last_row;
      pix.row_end   = row_done;
      pix.image_end = img_done;
   end

   // Next state.
   always_comb begin
      module_width_in = module_width_ff;
      margin_width_in = margin_width_ff;
      bar_height_in   = bar_height_ff;
      phase_in        = phase_ff;
      margin_count_in = margin_count_ff;
      module_index_in = module_index_ff;
      width_count_in  = width_count_ff;
      row_count_in    = row_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODULE_WIDTH: module_width_in = csr_wdata[4:0];
            CSR_MARGIN_WIDTH: margin_width_in = csr_wdata[6:0];
            CSR_BAR_HEIGHT:   bar_height_in   = csr_wdata;
            default:          module_width_in = module_width_ff;
         endcase
      end
      if (cfg_hit || restart) begin
         phase_in        = start_phase;
         margin_count_in = 7'd0;
         module_index_in = 7'd0;
         width_count_in  = 4'd0;
         row_count_in    = 10'd0;
      end else if (step) begin
         case (phase_ff)
            PH_BARS: begin
               if (wc_wrap) begin
                  width_count_in = 4'd0;
                  if (last_module) begin
                     module_index_in = 7'd0;
                     if (m_eff != 7'd0) begin
                        phase_in        = PH_RIGHT;
                        margin_count_in = 7'd0;
                     end
                  end else begin
                     module_index_in = idx_sum;
                  end
               end else begin
                  width_count_in  = wc_sum[3:0];
                  module_index_in = idx_cur;
               end
            end
            PH_RIGHT: begin
               margin_count_in = mc_sum[6:0];
            end
            default: begin
               if (mc_wrap) begin
                  margin_count_in = 7'd0;
                  phase_in        = PH_BARS;
                  module_index_in = 7'd0;
                  width_count_in  = 4'd0;
               end else begin
                  margin_count_in = mc_sum[6:0];
               end
            end
         endcase
         if (row_done) begin
            margin_count_in = 7'd0;
            module_index_in = 7'd0;
            width_count_in  = 4'd0;
            phase_in        = (m_eff == 7'd0) ? PH_BARS : PH_LEFT;
            row_count_in    = last_row ? 10'd0 : rc_sum[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_width_ff <= MODULE_WIDTH_RST;
         margin_width_ff <= MARGIN_WIDTH_RST;
         bar_height_ff   <= BAR_HEIGHT_RST;
         phase_ff        <= PH_LEFT;
         margin_count_ff <= 7'd0;
         module_index_ff <= 7'd0;
         width_count_ff  <= 4'd0;
         row_count_ff    <= 10'd0;
      end else begin
         module_width_ff <= module_width_in;
         margin_width_ff <= margin_width_in;
         bar_height_ff   <= bar_height_in;
         phase_ff        <= phase_in;
         margin_count_ff <= margin_count_in;
         module_index_ff <= module_index_in;
         width_count_ff  <= width_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   `ASSERT_SAME(a_width_in_range, clock, reset, 1'b1, ({1'b0, width_count_ff} < mw_eff))
   `ASSERT_SAME(a_right_has_margin, clock, reset, phase_ff == PH_RIGHT, m_eff != 7'd0)
   `ASSERT_SAME(a_module_in_row, clock, reset, 1'b1, module_index_ff < MODULES)
   `ASSERT_NEXT(a_restart_clears, clock, reset, restart, row_count_ff == 10'd0 && module_index_ff == 7'd0)

endmodule

// File: rtl/core/ean8_barcode_rasterizer.sv
// EAN-8 barcode rasterizer. A load item (mode 0) stores an eight-digit packed
// BCD code and answers with its check-digit status and a flag for any nibble
// above nine; each pixel item (mode 1) answers with the next pixel of a raster
// made of rows of left margin, 67 bar modules each module_width pixels wide, and
// right margin, repeated bar_height times, with row-end and image-end marks.
// Every item gives exactly one result. The block takes one item per clock and
// its result appears in the output register on the next cycle; a stall on the
// result side stops intake only while that register holds an untaken result.
// A load or any register write restarts the raster at its first pixel, and
// register writes are meant to happen only while no item is in flight.
`include "assert_macros.svh"

module ean8_barcode_rasterizer
   import ean8r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_code_bcd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic        rsp_pixel,
   output logic        rsp_row_end,
   output logic        rsp_image_end,
   output logic        rsp_check_ok,
   output logic        rsp_digit_error,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   logic            accept;
   logic            load;
   logic            step;
   code_status_type new_status;
   pix_info_type    pix;

   logic [31:0]     code_ff, code_in;
   code_status_type status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            kind_ff;
   pix_info_type    pix_ff;
   code_status_type rsp_status_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && !req_mode;
   assign step      = accept && req_mode;

   ean8r_check u_check (
      .code   (req_code_bcd),
      .status (new_status)
   );

   ean8r_raster u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .restart   (load),
      .step      (step),
      .code      (code_ff),
      .pix       (pix)
   );

   assign code_in      = load ? req_code_bcd : code_ff;
   assign status_in    = load ? new_status : status_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // The reset code of all zeros has a valid check digit.
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff               <= 32'd0;
         status_ff.check_ok    <= 1'b1;
         status_ff.digit_error <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         code_ff      <= code_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff       <= req_mode;
         pix_ff        <= req_mode ? pix : '0;
         rsp_status_ff <= req_mode ? status_ff : new_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_pixel       = pix_ff.pixel;
   assign rsp_row_end     = pix_ff.row_end;
   assign rsp_image_end   = pix_ff.image_end;
   assign rsp_check_ok    = rsp_status_ff.check_ok;
   assign rsp_digit_error = rsp_status_ff.digit_error;

   `ASSERT_SAME(a_image_ends_row, clock, reset, rsp_valid_ff && pix_ff.image_end, pix_ff.row_end)
   `ASSERT_SAME(a_load_no_pixel, clock, reset, rsp_valid_ff && !kind_ff, pix_ff == '0)
   `ASSERT_SAME(a_status_exclusive, clock, reset, rsp_valid_ff, !(rsp_status_ff.check_ok && rsp_status_ff.digit_error))
   `ASSERT_NEXT(a_load_updates_status, clock, reset, load, status_ff == rsp_status_ff)

endmodule
